// ===== rtl/sdr_pkg.sv =====
// shared types, constants and helpers of the scatter direction rotation block
package sdr_pkg;

  localparam int CORDIC_ITERS = 30;
  localparam int Q_SHIFT      = 30;
  localparam int QW           = 34;  // q30 sines, cosines and vector components
  localparam int ZW           = 33;  // rotation residue angle
  localparam int VW           = 36;  // vectoring datapath

  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

  localparam int SINCOS_LAT = CORDIC_ITERS + 2;
  localparam int MUL_LAT    = 7;
  localparam int SQRT_LAT   = 32;
  localparam int VEC_LAT    = CORDIC_ITERS + 1;
  localparam int TOTAL_LAT  = SINCOS_LAT + MUL_LAT + SQRT_LAT + VEC_LAT + 1;

  typedef logic signed [QW-1:0]   q_t;
  typedef logic signed [2*QW-1:0] qprod_t;
  typedef logic signed [VW-1:0]   v_t;

  localparam q_t CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    q_t                   x;
    q_t                   y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  typedef struct packed {
    v_t          x;
    v_t          y;
    logic [31:0] acc;
    logic        zero;
  } vec_t;

  // atan(2^-i) in turns scaled by 2^32
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    unique case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;  28: r = 32'h00000003;  29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // q30 product with floor rounding
  function automatic q_t qmul(input q_t a, input q_t b);
    qprod_t p;
    p = qprod_t'(a) * qprod_t'(b);
    return q_t'(p >>> Q_SHIFT);
  endfunction

endpackage

// ===== rtl/sdr_sincos.sv =====
// pipelined rotation cordic giving q30 sine and cosine of a turn angle
module sdr_sincos (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [31:0]   turn_i,
  output sdr_pkg::q_t   sin_o,
  output sdr_pkg::q_t   cos_o
);

  localparam int N = sdr_pkg::CORDIC_ITERS;

  sdr_pkg::rot_t st_q [N+1];
  sdr_pkg::rot_t pre_d;
  sdr_pkg::q_t   sin_q, cos_q;
  logic [31:0]   fold;

  // fold into -pi/2..pi/2 by a half turn
  always_comb begin
    pre_d.flip = (turn_i + sdr_pkg::QUARTER_TURN) >= sdr_pkg::HALF_TURN;
    fold       = pre_d.flip ? turn_i - sdr_pkg::HALF_TURN : turn_i;
    pre_d.x    = sdr_pkg::CORDIC_GAIN;
    pre_d.y    = '0;
    pre_d.z    = $signed({fold[31], fold});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= pre_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    sdr_pkg::rot_t nxt;
    always_comb begin
      nxt = st_q[i];
      if (!st_q[i].z[sdr_pkg::ZW-1]) begin
        nxt.x = st_q[i].x - (st_q[i].y >>> i);
        nxt.y = st_q[i].y + (st_q[i].x >>> i);
        nxt.z = st_q[i].z - $signed({1'b0, sdr_pkg::atan_turn(i)});
      end else begin
        nxt.x = st_q[i].x + (st_q[i].y >>> i);
        nxt.y = st_q[i].y - (st_q[i].x >>> i);
        nxt.z = st_q[i].z + $signed({1'b0, sdr_pkg::atan_turn(i)});
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= st_q[N].flip ? -st_q[N].y : st_q[N].y;
      cos_q <= st_q[N].flip ? -st_q[N].x : st_q[N].x;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== rtl/sdr_vector.sv =====
// pipelined vectoring cordic giving atan2(y, x) in turns scaled by 2^32
module sdr_vector (
  input  logic        clk_i,
  input  logic        en_i,
  input  sdr_pkg::v_t y_i,
  input  sdr_pkg::v_t x_i,
  output logic [31:0] angle_o
);

  localparam int N = sdr_pkg::CORDIC_ITERS;

  sdr_pkg::vec_t st_q [N+1];
  sdr_pkg::vec_t pre_d;

  // move into the right half plane
  always_comb begin
    pre_d.zero = (x_i == '0) && (y_i == '0);
    if (x_i[sdr_pkg::VW-1]) begin
      pre_d.x   = -x_i;
      pre_d.y   = -y_i;
      pre_d.acc = sdr_pkg::HALF_TURN;
    end else begin
      pre_d.x   = x_i;
      pre_d.y   = y_i;
      pre_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= pre_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    sdr_pkg::vec_t nxt;
    always_comb begin
      nxt = st_q[i];
      if (!st_q[i].y[sdr_pkg::VW-1]) begin
        nxt.x   = st_q[i].x + (st_q[i].y >>> i);
        nxt.y   = st_q[i].y - (st_q[i].x >>> i);
        nxt.acc = st_q[i].acc + sdr_pkg::atan_turn(i);
      end else begin
        nxt.x   = st_q[i].x - (st_q[i].y >>> i);
        nxt.y   = st_q[i].y + (st_q[i].x >>> i);
        nxt.acc = st_q[i].acc - sdr_pkg::atan_turn(i);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1] <= nxt;
      end
    end
  end

  assign angle_o = st_q[N].zero ? 32'h0 : st_q[N].acc;

endmodule

// ===== rtl/scatter_direction_rotation.sv =====
// top level: rotates a travel direction by a scattering angle pair, fully pipelined
//
//   channel  direction  handshake               payload
//   in       to block   in_valid_i/in_stall_o   polar, azimuth, scatter_polar, scatter_azimuth
//   out      from block out_valid_o/out_stall_i new_polar, new_azimuth
//
// one request enters per cycle while in_stall_o is low; each result passes 32 sin/cos
// cordic, 7 multiply/add, 32 square root, 31 vectoring cordic and 1 rounding stages
// reset clears only the valid bits and the output/skid flags
// a stalled output parks one result in a skid register; while it is full the whole
// pipeline holds and in_stall_o is high, so nothing is lost or repeated
module scatter_direction_rotation #(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] polar_i,
  input  logic [15:0] azimuth_i,
  input  logic [15:0] scatter_polar_i,
  input  logic [15:0] scatter_azimuth_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] new_polar_o,
  output logic [15:0] new_azimuth_o
);

  localparam int LAST = sdr_pkg::TOTAL_LAT - 1;
  localparam int SHIFT = 32 - ANGLE_BITS;
  localparam logic [31:0] CODE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [32:0] RND = 33'd1 << (31 - ANGLE_BITS);
  localparam logic [31:0] POL_TOP = sdr_pkg::HALF_TURN - (32'd1 << (31 - ANGLE_BITS));
  localparam logic [15:0] PI_CODE = 16'((32'd1 << (ANGLE_BITS - 1)) & 32'hFFFF);

  typedef struct packed {
    sdr_pkg::q_t stcp, ctcp, spcb, stsp, ctsp, cpcb, ctca, stsb, sa, ca, sb;
  } p1_t;
  typedef struct packed {
    sdr_pkg::q_t ax, bx, by, ay, zs, spcb, cpcb, ctca, sa;
  } p2_t;
  typedef struct packed {
    sdr_pkg::q_t dx, dy, z, ax, ay, sa;
  } p3_t;
  typedef struct packed {
    sdr_pkg::q_t ex, ey, z, ax, ay;
  } p4_t;
  typedef struct packed {
    sdr_pkg::q_t x, y, z;
  } p5_t;
  typedef struct packed {
    sdr_pkg::qprod_t xx, yy;
    sdr_pkg::q_t     x, y, z;
  } p6_t;
  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
    sdr_pkg::q_t x, y, z;
  } sq_t;
  typedef struct packed {
    logic [15:0] pol;
    logic [15:0] azi;
  } res_t;

  // pipeline moves whenever the skid register is free
  logic en;
  logic vld_q [sdr_pkg::TOTAL_LAT];
  logic skid_valid_q, out_valid_q;
  res_t skid_q, out_q, fin_q, fin_d;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sdr_pkg::TOTAL_LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < sdr_pkg::TOTAL_LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // angle codes to turns scaled by 2^32
  logic [31:0] t_pol, t_azi, t_spol, t_sazi;
  assign t_pol  = (32'(polar_i) & CODE_MASK) << SHIFT;
  assign t_azi  = (32'(azimuth_i) & CODE_MASK) << SHIFT;
  assign t_spol = (32'(scatter_polar_i) & CODE_MASK) << SHIFT;
  assign t_sazi = (32'(scatter_azimuth_i) & CODE_MASK) << SHIFT;

  sdr_pkg::q_t st, ct, sp, cp, sa, ca, sb, cb;

  sdr_sincos u_theta (.clk_i, .en_i(en), .turn_i(t_pol),  .sin_o(st), .cos_o(ct));
  sdr_sincos u_phi   (.clk_i, .en_i(en), .turn_i(t_azi),  .sin_o(sp), .cos_o(cp));
  sdr_sincos u_alpha (.clk_i, .en_i(en), .turn_i(t_spol), .sin_o(sa), .cos_o(ca));
  sdr_sincos u_beta  (.clk_i, .en_i(en), .turn_i(t_sazi), .sin_o(sb), .cos_o(cb));

  // new direction in the fixed frame, at most one multiply level per stage
  p1_t p1_q;
  p2_t p2_q;
  p3_t p3_q;
  p4_t p4_q;
  p5_t p5_q;
  p6_t p6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q.stcp <= sdr_pkg::qmul(st, cp);
      p1_q.ctcp <= sdr_pkg::qmul(ct, cp);
      p1_q.spcb <= sdr_pkg::qmul(sp, cb);
      p1_q.stsp <= sdr_pkg::qmul(st, sp);
      p1_q.ctsp <= sdr_pkg::qmul(ct, sp);
      p1_q.cpcb <= sdr_pkg::qmul(cp, cb);
      p1_q.ctca <= sdr_pkg::qmul(ct, ca);
      p1_q.stsb <= sdr_pkg::qmul(st, sb);
      p1_q.sa   <= sa;
      p1_q.ca   <= ca;
      p1_q.sb   <= sb;

      p2_q.ax   <= sdr_pkg::qmul(p1_q.stcp, p1_q.ca);
      p2_q.bx   <= sdr_pkg::qmul(p1_q.ctcp, p1_q.sb);
      p2_q.by   <= sdr_pkg::qmul(p1_q.ctsp, p1_q.sb);
      p2_q.ay   <= sdr_pkg::qmul(p1_q.stsp, p1_q.ca);
      p2_q.zs   <= sdr_pkg::qmul(p1_q.stsb, p1_q.sa);
      p2_q.spcb <= p1_q.spcb;
      p2_q.cpcb <= p1_q.cpcb;
      p2_q.ctca <= p1_q.ctca;
      p2_q.sa   <= p1_q.sa;

      p3_q.dx <= p2_q.bx - p2_q.spcb;
      p3_q.dy <= p2_q.by + p2_q.cpcb;
      p3_q.z  <= p2_q.ctca - p2_q.zs;
      p3_q.ax <= p2_q.ax;
      p3_q.ay <= p2_q.ay;
      p3_q.sa <= p2_q.sa;

      p4_q.ex <= sdr_pkg::qmul(p3_q.dx, p3_q.sa);
      p4_q.ey <= sdr_pkg::qmul(p3_q.dy, p3_q.sa);
      p4_q.z  <= p3_q.z;
      p4_q.ax <= p3_q.ax;
      p4_q.ay <= p3_q.ay;

      p5_q.x <= p4_q.ax + p4_q.ex;
      p5_q.y <= p4_q.ay + p4_q.ey;
      p5_q.z <= p4_q.z;

      p6_q.xx <= sdr_pkg::qprod_t'(p5_q.x) * sdr_pkg::qprod_t'(p5_q.x);
      p6_q.yy <= sdr_pkg::qprod_t'(p5_q.y) * sdr_pkg::qprod_t'(p5_q.y);
      p6_q.x  <= p5_q.x;
      p6_q.y  <= p5_q.y;
      p6_q.z  <= p5_q.z;
    end
  end

  // floor square root of x^2+y^2, one result bit per stage
  sq_t sq_q [sdr_pkg::SQRT_LAT+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].n   <= 64'(p6_q.xx) + 64'(p6_q.yy);
      sq_q[0].res <= '0;
      sq_q[0].x   <= p6_q.x;
      sq_q[0].y   <= p6_q.y;
      sq_q[0].z   <= p6_q.z;
    end
  end

  for (genvar k = 0; k < sdr_pkg::SQRT_LAT; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    sq_t         nxt;
    logic [63:0] trial;
    always_comb begin
      nxt   = sq_q[k];
      trial = sq_q[k].res + BIT;
      if (sq_q[k].n >= trial) begin
        nxt.n   = sq_q[k].n - trial;
        nxt.res = (sq_q[k].res >> 1) + BIT;
      end else begin
        nxt.res = sq_q[k].res >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1] <= nxt;
      end
    end
  end

  // polar as atan2(rho, z), azimuth as atan2(y, x)
  sq_t         sq_end;
  logic [31:0] pol_acc, azi_acc;
  assign sq_end = sq_q[sdr_pkg::SQRT_LAT];

  sdr_vector u_polar (
    .clk_i, .en_i(en),
    .y_i($signed({3'b000, sq_end.res[32:0]})),
    .x_i(sdr_pkg::v_t'(sq_end.z)),
    .angle_o(pol_acc)
  );

  sdr_vector u_azimuth (
    .clk_i, .en_i(en),
    .y_i(sdr_pkg::v_t'(sq_end.y)),
    .x_i(sdr_pkg::v_t'(sq_end.x)),
    .angle_o(azi_acc)
  );

  // clamp polar into 0..pi, round both to angle codes
  logic [31:0] pol_sat;
  logic [32:0] pol_rnd, azi_rnd;
  always_comb begin
    pol_sat = pol_acc;
    if (pol_acc > sdr_pkg::HALF_TURN) begin
      pol_sat = (pol_acc >= sdr_pkg::THREE_QUARTER_TURN) ? 32'h0 : sdr_pkg::HALF_TURN;
    end
    pol_rnd   = {1'b0, pol_sat} + RND;
    azi_rnd   = {1'b0, azi_acc} + RND;
    fin_d.pol = 16'(32'(pol_rnd >> SHIFT) & CODE_MASK);
    fin_d.azi = 16'(32'(azi_rnd >> SHIFT) & CODE_MASK);
    if (pol_sat >= POL_TOP) begin
      fin_d.pol = PI_CODE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  // output register with one skid entry behind it
  logic new_res, take;
  assign new_res = en && vld_q[LAST];
  assign take    = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || take) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= new_res;
        end
      end else if (new_res) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (new_res) begin
        out_q <= fin_q;
      end
    end else if (new_res) begin
      skid_q <= fin_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_polar_o   = out_q.pol;
  assign new_azimuth_o = out_q.azi;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (new_res && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("result leaving pipeline under stall was not parked");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> !skid_valid_q && out_valid_q)
    else $error("skid did not drain into output");

endmodule

// ===== tb/tb.sv =====
// testbench of the scatter direction rotation block: requests checked against a local model
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ABITS     = 16;
  localparam int ITERS     = 30;
  localparam int LATENCY   = 103;
  localparam int N_RANDOM  = 900;
  localparam int MAX_WAIT  = 12;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [31:0] HALF  = 32'h8000_0000;
  localparam logic [31:0] QUART = 32'h4000_0000;
  localparam longint GAIN = 652032874;

  typedef struct packed {
    logic [15:0] polar;
    logic [15:0] azimuth;
    logic [15:0] scat_polar;
    logic [15:0] scat_azimuth;
  } dir_req_t;

  typedef struct packed {
    logic [15:0] polar;
    logic [15:0] azimuth;
  } dir_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] polar_i = '0;
  logic [15:0] azimuth_i = '0;
  logic [15:0] scatter_polar_i = '0;
  logic [15:0] scatter_azimuth_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] new_polar_o;
  logic [15:0] new_azimuth_o;

  scatter_direction_rotation #(.ANGLE_BITS(ABITS)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .polar_i, .azimuth_i,
    .scatter_polar_i, .scatter_azimuth_i, .out_valid_o, .out_stall_i,
    .new_polar_o, .new_azimuth_o
  );

  always #1 clk_i = ~clk_i;

  dir_req_t pending_reqs[$];
  dir_res_t expected_dirs[$];
  int       n_errors = 0;
  longint   n_cycles = 0;
  bit       hold_sender = 1'b0;
  bit       in_taken = 1'b0;

  // queue helpers
  task automatic add_req(input dir_req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic add_expect(input dir_res_t d);
    expected_dirs = {expected_dirs, d};
  endtask

  // atan(2^-i) in turns scaled by 2^32
  function automatic longint atan_step(input int i);
    logic [31:0] t[ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    return longint'(t[i]);
  endfunction

  // q30 product, floor rounding via arithmetic shift
  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  // rotation cordic: sine and cosine of a 32-bit turn angle, q30
  task automatic turn_sincos(input logic [31:0] t, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = GAIN;
    y = 0;
    flip = 1'b0;
    if (((t + QUART) & HALF) != 0) begin
      t = t - HALF;
      flip = 1'b1;
    end
    z = longint'($signed(t));
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_step(i);
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  // vectoring cordic: atan2 as a turn accumulator, zero for the null vector
  function automatic logic [31:0] turn_atan2(input longint y, input longint x);
    logic [31:0] acc;
    longint nx;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = HALF;
    end
    for (int i = 0; i < ITERS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        acc = acc + 32'(atan_step(i));
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        acc = acc - 32'(atan_step(i));
      end
      x = nx;
    end
    return acc;
  endfunction

  function automatic longint floor_sqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [31:0] code_turn(input logic [15:0] c);
    return {c[ABITS-1:0], {(32-ABITS){1'b0}}};
  endfunction

  // round a turn accumulator to the nearest angle code, halves up
  function automatic logic [15:0] turn_code(input logic [31:0] t);
    logic [32:0] v;
    v = {1'b0, t} + (33'd1 << (31 - ABITS));
    return 16'(v[31:32-ABITS]);
  endfunction

  task automatic rotate_direction(input dir_req_t r, output dir_res_t d);
    longint st, ct, sp, cp, sa, ca, sb, cb, x, y, z, rho;
    logic [31:0] pol;
    logic [15:0] pcode;
    turn_sincos(code_turn(r.polar), st, ct);
    turn_sincos(code_turn(r.azimuth), sp, cp);
    turn_sincos(code_turn(r.scat_polar), sa, ca);
    turn_sincos(code_turn(r.scat_azimuth), sb, cb);
    x = q30_mul(q30_mul(st, cp), ca) +
        q30_mul(q30_mul(q30_mul(ct, cp), sb) - q30_mul(sp, cb), sa);
    y = q30_mul(q30_mul(st, sp), ca) +
        q30_mul(q30_mul(q30_mul(ct, sp), sb) + q30_mul(cp, cb), sa);
    z = q30_mul(ct, ca) - q30_mul(q30_mul(st, sb), sa);
    rho = floor_sqrt(64'(x * x) + 64'(y * y));
    pol = turn_atan2(rho, z);
    // polar residue beyond pi: clamp back into 0..pi
    if (pol > HALF) pol = (pol >= 32'hC000_0000) ? 32'h0 : HALF;
    pcode = turn_code(pol);
    if (pol >= HALF - (32'd1 << (31 - ABITS))) pcode = 16'(1 << (ABITS - 1));
    d.polar = pcode;
    d.azimuth = turn_code(turn_atan2(y, x));
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  function automatic dir_req_t random_req();
    dir_req_t r;
    // mostly in-range angles, sometimes any code (taken modulo 2pi)
    if ($urandom_range(0, 7) == 0) begin
      r = {$urandom, $urandom};
    end else begin
      r.polar = 16'($urandom_range(0, 32768));
      r.azimuth = 16'($urandom);
      r.scat_polar = 16'($urandom_range(0, 32768));
      r.scat_azimuth = 16'($urandom);
    end
    return r;
  endfunction

  // driver: one request at a time, sometimes back to back, else after a random gap, held while stalled
  int send_gap = 0;
  always @(negedge clk_i) begin
    dir_req_t r;
    if (rst_ni) begin
      if (in_valid_i && in_taken) begin
        // accepted at the last rising edge
        if (pending_reqs.size() > 0 && !hold_sender && send_gap == 0 &&
            $urandom_range(0, 3) != 0) begin
          r = pending_reqs.pop_front();
          {polar_i, azimuth_i, scatter_polar_i, scatter_azimuth_i} <= r;
        end else begin
          in_valid_i <= 1'b0;
          send_gap = $urandom_range(0, MAX_WAIT);
        end
      end else if (!in_valid_i) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          r = pending_reqs.pop_front();
          {polar_i, azimuth_i, scatter_polar_i, scatter_azimuth_i} <= r;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // prediction at acceptance, handshake seen as it was at the rising edge
  always @(posedge clk_i) begin
    dir_res_t d;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      rotate_direction({polar_i, azimuth_i, scatter_polar_i, scatter_azimuth_i}, d);
      add_expect(d);
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    dir_res_t want;
    n_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_dirs.size() == 0) begin
        report_mismatch("unexpected new_polar", new_polar_o, '0);
      end else begin
        want = expected_dirs.pop_front();
        if (new_polar_o !== want.polar) report_mismatch("new_polar", new_polar_o, want.polar);
        if (new_azimuth_o !== want.azimuth)
          report_mismatch("new_azimuth", new_azimuth_o, want.azimuth);
      end
    end
  end

  // receiver stall: random lengths, quiet stretches in between
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!out_stall_i && $urandom_range(0, 5) == 0 && (n_cycles / 2000) % 3 != 2) begin
      stall_left = $urandom_range(0, MAX_WAIT);
    end
    out_stall_i <= (stall_left > 0);
  end

  always @(posedge clk_i) begin
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic dir_req_t mk(input int p, input int a, input int sp, input int sa);
    return {16'(p), 16'(a), 16'(sp), 16'(sa)};
  endfunction

  initial begin
    // directed: poles, zero scattering, back-scatter, azimuth wrap and odd codes
    add_req(mk(0, 0, 0, 0));
    add_req(mk(32768, 0, 0, 0));
    add_req(mk(16384, 0, 0, 0));
    add_req(mk(16384, 32767, 0, 0));
    add_req(mk(16384, 16'h8000, 0, 0));
    add_req(mk(16384, 16384, 32768, 0));
    add_req(mk(0, 0, 32768, 0));
    add_req(mk(32768, 0, 32768, 0));
    add_req(mk(0, 0, 16384, 0));
    add_req(mk(0, 0, 16384, 16384));
    add_req(mk(0, 0, 16384, 65535));
    add_req(mk(16384, 0, 16384, 49152));
    add_req(mk(32768, 16'h8000, 32768, 65535));
    add_req(mk(1, 16'hFFFF, 1, 1));
    add_req(mk(32767, 1, 32767, 32768));
    add_req(mk(65535, 65535, 65535, 65535));
    add_req(mk(49152, 12345, 40000, 777));
    add_req(mk(16384, 0, 16384, 32768));
    add_req(mk(12000, 16'hA000, 5000, 30000));
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // drain: let every request in flight come out before going on
        wait (pending_reqs.size() == 0);
        hold_sender = 1'b1;
        @(posedge clk_i);
        wait (!in_valid_i && expected_dirs.size() == 0);
        hold_sender = 1'b0;
      end
      add_req(random_req());
    end
    wait (pending_reqs.size() == 0);
    @(negedge clk_i);
    wait (!in_valid_i && expected_dirs.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (n_errors == 0 && expected_dirs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/sdr_pkg.sv
rtl/sdr_sincos.sv
rtl/sdr_vector.sv
rtl/scatter_direction_rotation.sv
tb/tb.sv
